>>> hdl/oale_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// oale_pkg
// Shared types and constants of the ordered array list engine: request and
// result formats, operation and status codes, controller state encoding and
// the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package oale_pkg;

    // Field widths
    localparam int unsigned MODE_W = 3;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned STAT_W = 2;

    // Default store depth and capacity after reset
    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EDIT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Request payload
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] write_data;
    } t_request;

    // Result payload
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]         entry_count;
        logic                     empty_flag;
        logic                     full_flag;
    } t_result;

    // Controller states
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECIDE,
        CS_SHIFT,
        CS_DRAIN,
        CS_STORE,
        CS_FINISH
    } t_ctrl_state;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture request and check it
        logic shift_init; // set up shift pointers
        logic shift_rd;   // read one entry of the shift run
        logic rd_idx;     // read the entry at the request index
        logic store;      // write the request word
        logic finish;     // update count and present the result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              err;
        logic              shift_none;
        logic              shift_last;
    } t_dp_status;

endpackage : oale_pkg
`default_nettype wire

>>> hdl/ordered_array_list_engine_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ordered_array_list_engine_core
// Ordered list of signed words with insert, append, read, edit and delete.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows on o_result, marked by o_done for a single cycle, and it must be
// captured then because the engine cannot be held off. Edit, append, an unused
// mode code, any failed request, an insert at the end of the list and a delete
// of the last entry finish straight from the decide state; a read passes
// through a finish state; any other insert or delete first moves the later
// words one place up or down, and an insert then stores its word there.
// The shift moves one word per cycle through the single write port of the
// entry store. The result strobe comes in the first cycle with busy low, and
// the next request can be taken at the edge that ends it. Capacity is written
// on i_cfg_we; the user must assert it only while busy is low, which the block
// does not enforce. A capacity write empties the list.
// ---------------------------------------------------------------------------
module ordered_array_list_engine_core #(
    parameter int unsigned DEPTH = oale_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire oale_pkg::t_request         i_request,
    input  wire logic                       i_cfg_we,
    input  wire logic [oale_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                            o_done,
    output oale_pkg::t_result               o_result
);

    oale_pkg::t_dp_cmd    cmd;
    oale_pkg::t_dp_status dp_status;
    logic                 ctrl_busy;

    // Sequencer
    oale_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (ctrl_busy),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    // Datapath and entry store
    oale_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (dp_status),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    assign busy = ctrl_busy;

endmodule : ordered_array_list_engine_core
`default_nettype wire

>>> hdl/oale_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// oale_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module oale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule : oale_ram
`default_nettype wire

>>> hdl/oale_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// oale_ctrl
// Sequencer of the list engine: decides per request whether it finishes at
// once, needs a single store or read, or runs a shift through the store.
// ---------------------------------------------------------------------------
module oale_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire oale_pkg::t_dp_status i_status,
    output oale_pkg::t_dp_cmd         o_cmd
);

    oale_pkg::t_ctrl_state r_state;
    oale_pkg::t_ctrl_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oale_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            oale_pkg::CS_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = oale_pkg::CS_DECIDE;
                end
            end
            oale_pkg::CS_DECIDE: begin
                if (i_status.err) begin
                    o_cmd.finish = 1'b1;
                    n_state      = oale_pkg::CS_IDLE;
                end else begin
                    case (i_status.mode)
                        oale_pkg::MODE_APPEND, oale_pkg::MODE_EDIT: begin
                            o_cmd.store  = 1'b1;
                            o_cmd.finish = 1'b1;
                            n_state      = oale_pkg::CS_IDLE;
                        end
                        oale_pkg::MODE_READ: begin
                            o_cmd.rd_idx = 1'b1;
                            n_state      = oale_pkg::CS_FINISH;
                        end
                        oale_pkg::MODE_INSERT: begin
                            if (i_status.shift_none) begin
                                o_cmd.store  = 1'b1;
                                o_cmd.finish = 1'b1;
                                n_state      = oale_pkg::CS_IDLE;
                            end else begin
                                o_cmd.shift_init = 1'b1;
                                n_state          = oale_pkg::CS_SHIFT;
                            end
                        end
                        oale_pkg::MODE_DELETE: begin
                            if (i_status.shift_none) begin
                                o_cmd.finish = 1'b1;
                                n_state      = oale_pkg::CS_IDLE;
                            end else begin
                                o_cmd.shift_init = 1'b1;
                                n_state          = oale_pkg::CS_SHIFT;
                            end
                        end
                        default: begin
                            // unused codes report the flags only
                            o_cmd.finish = 1'b1;
                            n_state      = oale_pkg::CS_IDLE;
                        end
                    endcase
                end
            end
            oale_pkg::CS_SHIFT: begin
                o_cmd.shift_rd = 1'b1;
                if (i_status.shift_last) begin
                    n_state = oale_pkg::CS_DRAIN;
                end
            end
            oale_pkg::CS_DRAIN: begin
                // last moved word is written by the datapath this cycle
                if (i_status.mode == oale_pkg::MODE_INSERT) begin
                    n_state = oale_pkg::CS_STORE;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = oale_pkg::CS_IDLE;
                end
            end
            oale_pkg::CS_STORE: begin
                o_cmd.store  = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = oale_pkg::CS_IDLE;
            end
            oale_pkg::CS_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = oale_pkg::CS_IDLE;
            end
            default: begin
                n_state = oale_pkg::CS_IDLE;
            end
        endcase
    end

    assign busy = (r_state != oale_pkg::CS_IDLE);

endmodule : oale_ctrl
`default_nettype wire

>>> hdl/oale_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// oale_datapath
// Request registers, error checks, count and capacity, shift pointers,
// the entry store and the result register.
// ---------------------------------------------------------------------------
module oale_datapath #(
    parameter int unsigned DEPTH = oale_pkg::DEPTH_DEFAULT,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire oale_pkg::t_request            i_request,
    input  wire logic                          i_cfg_we,
    input  wire logic [oale_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  wire oale_pkg::t_dp_cmd             i_cmd,
    output oale_pkg::t_dp_status               o_status,
    output logic                               o_done,
    output oale_pkg::t_result                  o_result
);

    localparam int unsigned CNT_W  = oale_pkg::CNT_W;
    localparam int unsigned DATA_W = oale_pkg::DATA_W;
    // largest capacity the store and the count field can both hold
    localparam int unsigned CAP_MAX = (DEPTH < 127) ? DEPTH : 127;

    // Request registers (payload)
    logic [oale_pkg::MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]            r_idx;
    logic [DATA_W-1:0]           r_wdata;
    oale_pkg::t_status           r_status;
    oale_pkg::t_status           n_status;

    // Control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_capacity;
    logic [CNT_W-1:0] eff_cap;
    logic             r_done;
    logic             r_pend;

    // Shift pointers
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_end;
    logic [AW-1:0] r_wr_addr;
    logic          is_ins;

    // Store access
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    oale_pkg::t_result r_result;
    logic [CNT_W-1:0]  req_idx;

    assign eff_cap = (r_capacity > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : r_capacity;
    assign req_idx = {1'b0, i_request.index};
    assign is_ins  = (r_mode == oale_pkg::MODE_INSERT);

    // Error checks on the incoming request, in priority order
    always_comb begin
        n_status = oale_pkg::ST_OK;
        case (i_request.mode)
            oale_pkg::MODE_INSERT: begin
                if (req_idx > r_count) begin
                    n_status = oale_pkg::ST_BOUNDS;
                end else if (r_count >= eff_cap) begin
                    n_status = oale_pkg::ST_FULL;
                end
            end
            oale_pkg::MODE_APPEND: begin
                if (r_count >= eff_cap) begin
                    n_status = oale_pkg::ST_FULL;
                end
            end
            oale_pkg::MODE_READ, oale_pkg::MODE_EDIT, oale_pkg::MODE_DELETE: begin
                if (r_count == '0) begin
                    n_status = oale_pkg::ST_EMPTY;
                end else if (req_idx >= r_count) begin
                    n_status = oale_pkg::ST_BOUNDS;
                end
            end
            default: begin
                n_status = oale_pkg::ST_OK;
            end
        endcase
    end

    // Capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_request.mode;
            r_idx    <= req_idx;
            r_wdata  <= i_request.write_data;
            r_status <= n_status;
        end
    end

    // Status towards the controller
    always_comb begin
        o_status.mode       = r_mode;
        o_status.err        = (r_status != oale_pkg::ST_OK);
        o_status.shift_none = is_ins ? (r_count == r_idx)
                                     : (CNT_W'(r_idx + 1'b1) == r_count);
        o_status.shift_last = (r_ptr == r_end);
    end

    // Shift pointers: insert walks down from the top, delete walks up
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_init) begin
            if (is_ins) begin
                r_ptr <= AW'(CNT_W'(r_count - 1'b1));
                r_end <= AW'(r_idx);
            end else begin
                r_ptr <= AW'(CNT_W'(r_idx + 1'b1));
                r_end <= AW'(CNT_W'(r_count - 1'b1));
            end
        end else if (i_cmd.shift_rd) begin
            r_ptr <= is_ins ? AW'(r_ptr - 1'b1) : AW'(r_ptr + 1'b1);
        end
        if (i_cmd.shift_rd) begin
            r_wr_addr <= is_ins ? AW'(r_ptr + 1'b1) : AW'(r_ptr - 1'b1);
        end
    end

    // Pending move: word read last cycle is written one place over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.shift_rd;
        end
    end

    // Store port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        if (r_pend) begin
            ram_we = 1'b1;
        end else if (i_cmd.store) begin
            ram_we    = 1'b1;
            ram_waddr = (r_mode == oale_pkg::MODE_APPEND) ? AW'(r_count) : AW'(r_idx);
            ram_wdata = r_wdata;
        end
        ram_raddr = i_cmd.rd_idx ? AW'(r_idx) : r_ptr;
    end

    oale_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Count after the request
    always_comb begin
        n_count = r_count;
        if (r_status == oale_pkg::ST_OK) begin
            case (r_mode)
                oale_pkg::MODE_INSERT, oale_pkg::MODE_APPEND: begin
                    n_count = CNT_W'(r_count + 1'b1);
                end
                oale_pkg::MODE_DELETE: begin
                    n_count = CNT_W'(r_count - 1'b1);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Count and capacity; a capacity write empties the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= oale_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_count    <= '0;
            r_capacity <= i_cfg_wdata;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.status      <= r_status;
            r_result.entry_count <= n_count;
            r_result.empty_flag  <= (n_count == '0);
            r_result.full_flag   <= (n_count == eff_cap);
            if (r_mode != oale_pkg::MODE_READ) begin
                r_result.read_data <= '0;
            end else if (r_status != oale_pkg::ST_OK) begin
                r_result.read_data <= '1;
            end else begin
                r_result.read_data <= ram_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule : oale_datapath
`default_nettype wire

>>> tb/tb_ordered_array_list_engine_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ordered_array_list_engine_core
// Self-checking bench for the ordered array list engine. A queue of requests
// and capacity writes is built up front: a directed set covering the empty,
// full, bounds and spare-mode cases, then random phases at several
// capacities (zero, one, the store depth, above it). A clocked driver issues
// them with random gaps; each accepted request is run through a shadow list
// to give the expected result, which a clocked monitor checks field by field
// against the engine's strobed result.
// ---------------------------------------------------------------------------
module tb_ordered_array_list_engine_core;

    localparam int unsigned MODE_W = oale_pkg::MODE_W;
    localparam int unsigned IDX_W  = oale_pkg::IDX_W;
    localparam int unsigned DATA_W = oale_pkg::DATA_W;
    localparam int unsigned CNT_W  = oale_pkg::CNT_W;

    localparam int unsigned LIST_DEPTH    = oale_pkg::DEPTH_DEFAULT;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 2 * oale_pkg::DEPTH_DEFAULT + 16;
    localparam int unsigned LIMIT_CYCLES  = 1000000;
    localparam int unsigned SHOWN_FAULTS  = 10;

    // Spare operation codes: the engine must report them as a no-op
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef enum logic {FEED_REQ, FEED_CAP} t_feed_kind;

    typedef struct {
        t_feed_kind         kind;
        oale_pkg::t_request req;
        logic [CNT_W-1:0]   cap;
    } t_feed_item;

    // DUT signals
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    oale_pkg::t_request i_request = '0;
    logic               i_cfg_we = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;
    logic               o_done;
    oale_pkg::t_result  o_result;

    // Stimulus feed and expected results
    t_feed_item        request_feed[$];
    oale_pkg::t_result due_results[$];
    t_feed_item        fed;

    // Shadow list, advanced at each accepted request
    logic signed [DATA_W-1:0] shadow_words [LIST_DEPTH];
    logic [CNT_W-1:0]         shadow_len;
    logic [CNT_W-1:0]         shadow_cap;

    // Entry count as the stimulus builder expects it, used to aim indices
    int unsigned plan_len;
    int unsigned plan_cap;

    int unsigned gap_left;
    int unsigned settle_left;
    int unsigned accepted;
    int unsigned cap_writes;
    int unsigned results_checked;
    int unsigned faults;
    int unsigned cycles;
    int unsigned status_seen [4];

    ordered_array_list_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // Clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Expected result of one request; updates the shadow list
    function automatic oale_pkg::t_result list_apply(input oale_pkg::t_request rq);
        oale_pkg::t_result res;
        int unsigned       lim;
        int                i;
        lim = (shadow_cap > LIST_DEPTH) ? LIST_DEPTH : shadow_cap;
        res = '0;
        res.status = oale_pkg::ST_OK;
        case (rq.mode)
            oale_pkg::MODE_INSERT: begin
                if (rq.index > shadow_len) begin
                    res.status = oale_pkg::ST_BOUNDS;
                end else if (shadow_len >= lim) begin
                    res.status = oale_pkg::ST_FULL;
                end else begin
                    for (i = shadow_len; i > rq.index; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[rq.index] = rq.write_data;
                    shadow_len++;
                end
            end
            oale_pkg::MODE_APPEND: begin
                if (shadow_len >= lim) begin
                    res.status = oale_pkg::ST_FULL;
                end else begin
                    shadow_words[shadow_len] = rq.write_data;
                    shadow_len++;
                end
            end
            oale_pkg::MODE_READ: begin
                if (shadow_len == 0) begin
                    res.status = oale_pkg::ST_EMPTY;
                    res.read_data = '1;
                end else if (rq.index >= shadow_len) begin
                    res.status = oale_pkg::ST_BOUNDS;
                    res.read_data = '1;
                end else begin
                    res.read_data = shadow_words[rq.index];
                end
            end
            oale_pkg::MODE_EDIT: begin
                if (shadow_len == 0)
                    res.status = oale_pkg::ST_EMPTY;
                else if (rq.index >= shadow_len)
                    res.status = oale_pkg::ST_BOUNDS;
                else
                    shadow_words[rq.index] = rq.write_data;
            end
            oale_pkg::MODE_DELETE: begin
                if (shadow_len == 0) begin
                    res.status = oale_pkg::ST_EMPTY;
                end else if (rq.index >= shadow_len) begin
                    res.status = oale_pkg::ST_BOUNDS;
                end else begin
                    for (i = rq.index; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            default: ;
        endcase
        res.entry_count = shadow_len;
        res.empty_flag  = (shadow_len == 0);
        res.full_flag   = (shadow_len == lim);
        return res;
    endfunction

    // Gap after a request: mostly short, a few long, some runs with none
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((accepted / 64) % 4 == 3)
            return 0;
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // Queue a request and track the count it should leave
    task automatic add_req(input logic [MODE_W-1:0] mode, input int unsigned idx,
                           input logic [DATA_W-1:0] data);
        t_feed_item  it;
        int unsigned lim;
        lim = (plan_cap > LIST_DEPTH) ? LIST_DEPTH : plan_cap;
        it.kind = FEED_REQ;
        it.cap = '0;
        it.req.mode = mode;
        it.req.index = idx[IDX_W-1:0];
        it.req.write_data = data;
        request_feed.push_back(it);
        case (mode)
            oale_pkg::MODE_INSERT: if (idx <= plan_len && plan_len < lim) plan_len++;
            oale_pkg::MODE_APPEND: if (plan_len < lim) plan_len++;
            oale_pkg::MODE_DELETE: if (idx < plan_len) plan_len--;
            default: ;
        endcase
    endtask

    task automatic add_cap(input int unsigned cap);
        t_feed_item it;
        it.kind = FEED_CAP;
        it.req = '0;
        it.cap = cap[CNT_W-1:0];
        request_feed.push_back(it);
        plan_cap = cap;
        plan_len = 0;
    endtask

    // Driver: requests with random gaps, capacity writes only when idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left <= 0;
            settle_left <= SETTLE_CYCLES;
            shadow_len = '0;
            shadow_cap = oale_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            // capacity written at this edge; the list empties
            shadow_cap = i_cfg_wdata;
            shadow_len = '0;
            cap_writes++;
            i_cfg_we <= 1'b0;
        end else if (start) begin
            if (!busy) begin
                due_results.push_back(list_apply(i_request));
                accepted++;
                gap_left <= pick_gap();
                if (request_feed.size() > 0 && request_feed[0].kind == FEED_REQ &&
                    pick_gap() == 0) begin
                    fed = request_feed.pop_front();
                    i_request <= fed.req;
                end else begin
                    start <= 1'b0;
                end
            end
        end else if (request_feed.size() > 0) begin
            if (request_feed[0].kind == FEED_CAP) begin
                if (due_results.size() == 0 && !busy) begin
                    if (settle_left == 0) begin
                        fed = request_feed.pop_front();
                        i_cfg_wdata <= fed.cap;
                        i_cfg_we <= 1'b1;
                        settle_left <= SETTLE_CYCLES;
                    end else begin
                        settle_left <= settle_left - 1;
                    end
                end
            end else if (gap_left == 0) begin
                fed = request_feed.pop_front();
                i_request <= fed.req;
                start <= 1'b1;
            end else begin
                gap_left <= gap_left - 1;
            end
        end
    end

    // Monitor: every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                faults++;
                if (faults <= SHOWN_FAULTS)
                    $display("%0t: result with none expected: st=%0d rd=%0d cnt=%0d e=%0d f=%0d",
                             $realtime, o_result.status, o_result.read_data,
                             o_result.entry_count, o_result.empty_flag, o_result.full_flag);
            end else begin
                oale_pkg::t_result want;
                want = due_results.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (o_result.status !== want.status || o_result.read_data !== want.read_data ||
                    o_result.entry_count !== want.entry_count ||
                    o_result.empty_flag !== want.empty_flag ||
                    o_result.full_flag !== want.full_flag) begin
                    faults++;
                    if (faults <= SHOWN_FAULTS) begin
                        $display("%0t: mismatch on result %0d", $realtime, results_checked);
                        $display("  expected st=%0d rd=%0d cnt=%0d e=%0d f=%0d",
                                 want.status, want.read_data, want.entry_count,
                                 want.empty_flag, want.full_flag);
                        $display("  actual   st=%0d rd=%0d cnt=%0d e=%0d f=%0d",
                                 o_result.status, o_result.read_data, o_result.entry_count,
                                 o_result.empty_flag, o_result.full_flag);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int unsigned phase_caps [10];
        int unsigned phase_len  [10];
        int unsigned p, n, r, idx, stint;
        bit          grow;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] data;

        phase_caps = '{64, 2, 127, 1, 65, 0, 16, 0, 64, 33};
        phase_len  = '{200, 80, 180, 60, 150, 25, 120, 120, 180, 100};
        phase_caps[7] = $urandom_range(3, 63);
        plan_cap = oale_pkg::CAPACITY_RESET;
        plan_len = 0;

        // Directed: empty list at reset capacity
        add_req(oale_pkg::MODE_READ,   0, 32'h0000_0000);
        add_req(oale_pkg::MODE_EDIT,   0, 32'h1234_5678);
        add_req(oale_pkg::MODE_DELETE, 0, 32'h0000_0000);
        add_req(oale_pkg::MODE_INSERT, 1, 32'h0000_0001);
        // build a short list: front, back, middle and end inserts
        add_req(oale_pkg::MODE_INSERT, 0, 32'h8000_0000);
        add_req(oale_pkg::MODE_APPEND, 0, 32'h7fff_ffff);
        add_req(oale_pkg::MODE_APPEND, 0, 32'hffff_ffff);
        add_req(oale_pkg::MODE_INSERT, 1, 32'h0000_0000);
        add_req(oale_pkg::MODE_INSERT, 4, 32'h5555_5555);
        add_req(oale_pkg::MODE_INSERT, 6, 32'h0000_0002);
        add_req(oale_pkg::MODE_READ,   0, 32'h0000_0000);
        add_req(oale_pkg::MODE_READ,   4, 32'h0000_0000);
        add_req(oale_pkg::MODE_READ,  63, 32'h0000_0000);
        add_req(oale_pkg::MODE_EDIT,   2, 32'haaaa_aaaa);
        add_req(oale_pkg::MODE_EDIT,   5, 32'h0000_0003);
        add_req(oale_pkg::MODE_DELETE, 0, 32'h0000_0000);
        add_req(oale_pkg::MODE_DELETE, 4, 32'h0000_0000);
        add_req(oale_pkg::MODE_DELETE, 3, 32'h0000_0000);
        add_req(MODE_SPARE_FIRST, 0, 32'h0000_0000);
        add_req(MODE_SPARE_LAST, 63, 32'hffff_ffff);
        // capacity of one: fills after a single word
        add_cap(1);
        add_req(oale_pkg::MODE_APPEND, 0, 32'h0000_00ff);
        add_req(oale_pkg::MODE_INSERT, 0, 32'h0000_0004);
        add_req(oale_pkg::MODE_APPEND, 0, 32'h0000_0005);
        // capacity zero: empty and full at once
        add_cap(0);
        add_req(oale_pkg::MODE_INSERT, 0, 32'h0000_0006);
        add_req(oale_pkg::MODE_INSERT, 1, 32'h0000_0007);
        add_req(oale_pkg::MODE_READ,   0, 32'h0000_0000);

        // Random phases; alternate stints of growing and shrinking the list
        for (p = 0; p < 10; p++) begin
            add_cap(phase_caps[p]);
            grow = 1'b1;
            stint = $urandom_range(30, 140);
            for (n = 0; n < phase_len[p]; n++) begin
                if (stint == 0) begin
                    grow = !grow;
                    stint = $urandom_range(30, 140);
                end
                stint--;
                r = $urandom_range(0, 99);
                if (r >= 95) begin
                    r = $urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST);
                    mode = r[MODE_W-1:0];
                end else if (r < (grow ? 35 : 12))
                    mode = oale_pkg::MODE_INSERT;
                else if (r < (grow ? 55 : 20))
                    mode = oale_pkg::MODE_APPEND;
                else if (r < (grow ? 72 : 40))
                    mode = oale_pkg::MODE_READ;
                else if (r < (grow ? 85 : 52))
                    mode = oale_pkg::MODE_EDIT;
                else
                    mode = oale_pkg::MODE_DELETE;
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    if (mode == oale_pkg::MODE_INSERT)
                        idx = $urandom_range(0, plan_len);
                    else
                        idx = (plan_len > 0) ? $urandom_range(0, plan_len - 1) : 0;
                end else if (r < 8) begin
                    idx = plan_len;
                end else begin
                    idx = $urandom_range(0, LIST_DEPTH - 1);
                end
                if (idx >= LIST_DEPTH)
                    idx = LIST_DEPTH - 1;
                r = $urandom_range(0, 19);
                data = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7fff_ffff :
                       (r == 2) ? 32'hffff_ffff : $urandom;
                add_req(mode, idx, data);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the feed and the results to drain, then a tail for strays
        while (request_feed.size() > 0 || start || i_cfg_we || due_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (due_results.size() > 0) begin
            $display("%0d expected results never arrived", due_results.size());
            faults += due_results.size();
        end
        $display("Checked %0d results from %0d requests across %0d capacity writes.",
                 results_checked, accepted, cap_writes);
        $display("Status mix: ok %0d, bounds %0d, full %0d, empty %0d; faults %0d.",
                 status_seen[oale_pkg::ST_OK], status_seen[oale_pkg::ST_BOUNDS],
                 status_seen[oale_pkg::ST_FULL], status_seen[oale_pkg::ST_EMPTY], faults);
        if (faults == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/oale_pkg.sv
hdl/oale_ram.sv
hdl/oale_ctrl.sv
hdl/oale_datapath.sv
hdl/ordered_array_list_engine_core.sv
tb/tb_ordered_array_list_engine_core.sv
